// ===== rtl/csf_pkg.sv =====
package csf_pkg;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FEW = 2'd1;
  localparam logic [1:0] STATUS_OVF = 2'd2;

  localparam logic [3:0] REG_NUM_VARS = 4'd0;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR_AB,
    OP_ADD_TERM,
    OP_SQRT_START,
    OP_SQRT_STEP,
    OP_ADD_DIST,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_POW_INIT,
    OP_POW_MUL,
    OP_POW_SHIFT,
    OP_NDIV_START,
    OP_NDIV_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_a;
    logic   load_b;
  } dp_cmd_t;

  typedef struct packed {
    logic step_done;
    logic pow_huge;
  } dp_stat_t;

endpackage

// ===== rtl/csf_ram.sv =====
module csf_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/csf_datapath.sv =====
// Arithmetic datapath: squared-difference accumulate, bit-serial sqrt,
// bit-serial dividers, and a 32x32 partial-product power loop.
module csf_datapath (
  input  logic               clk,
  input  csf_pkg::dp_cmd_t   cmd,
  input  logic [15:0]        rdata,
  input  logic [19:0]        npairs,
  input  logic [10:0]        npts,
  output csf_pkg::dp_stat_t  stat,
  output logic [31:0]        mean,
  output logic [63:0]        sparsity
);

  logic signed [15:0] a;
  logic signed [15:0] b;
  logic [36:0]  ssum;
  logic [52:0]  sq_v;
  logic [52:0]  sq_r;
  logic [52:0]  sq_bit;
  logic [47:0]  total;
  logic [47:0]  dv_q;
  logic [47:0]  dv_r;
  logic [5:0]   cnt;
  logic [95:0]  pw;
  logic [127:0] prod;
  logic [1:0]   pph;
  logic         huge;

  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic [52:0]        sq_t;
  logic [48:0]        rem_sh;
  logic [48:0]        rem_sub;
  logic [48:0]        nd_sh;
  logic [48:0]        nd_sub;

  assign diff = 17'(a) - 17'(b);
  assign mag = diff[16] ? 17'(-diff) : diff;
  assign sq_t = sq_r + sq_bit;
  assign rem_sh = {dv_r, dv_q[47]};
  assign rem_sub = rem_sh - 49'(npairs);
  assign nd_sh = {dv_r, sparsity[63]};
  assign nd_sub = nd_sh - 49'(npts);

  always_ff @(posedge clk) begin
    if (cmd.load_a) a <= rdata;
    if (cmd.load_b) b <= rdata;
    case (cmd.op)
      csf_pkg::OP_CLEAR_AB: begin
        ssum <= '0;
        total <= '0;
      end
      csf_pkg::OP_ADD_TERM: begin
        ssum <= ssum + 37'(mag * mag);
      end
      csf_pkg::OP_SQRT_START: begin
        sq_v <= {ssum, 16'd0};
        sq_r <= '0;
        sq_bit <= 53'd1 << 52;
        cnt <= 6'd26;
      end
      csf_pkg::OP_SQRT_STEP: begin
        if (sq_v >= sq_t) begin
          sq_v <= sq_v - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        cnt <= cnt - 6'd1;
        ssum <= '0;
      end
      csf_pkg::OP_ADD_DIST: begin
        total <= total + 48'(sq_r);
      end
      csf_pkg::OP_DIV_START: begin
        dv_q <= total;
        dv_r <= '0;
        cnt <= 6'd47;
      end
      csf_pkg::OP_DIV_STEP: begin
        if (!rem_sub[48]) begin
          dv_r <= rem_sub[47:0];
          dv_q <= {dv_q[46:0], 1'b1};
        end else begin
          dv_r <= rem_sh[47:0];
          dv_q <= {dv_q[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
      end
      csf_pkg::OP_POW_INIT: begin
        mean <= dv_q[31:0];
        pw <= 96'd1 << 32;
        huge <= 1'b0;
        pph <= 2'd0;
        prod <= '0;
      end
      csf_pkg::OP_POW_MUL: begin
        prod <= prod + (128'(64'(pw[32*pph +: 32]) * 64'(mean)) << (32*pph));
        pph <= (pph == 2'd2) ? 2'd0 : pph + 2'd1;
      end
      csf_pkg::OP_POW_SHIFT: begin
        pw <= prod[111:16];
        if (prod[127:112] != '0) huge <= 1'b1;
        prod <= '0;
      end
      csf_pkg::OP_NDIV_START: begin
        dv_r <= 48'(pw[95:64]);
        cnt <= 6'd63;
        sparsity <= pw[63:0];
        if (pw[95:64] >= 32'(npts)) huge <= 1'b1;
      end
      csf_pkg::OP_NDIV_STEP: begin
        if (!nd_sub[48]) begin
          dv_r <= nd_sub[47:0];
          sparsity <= {sparsity[62:0], 1'b1};
        end else begin
          dv_r <= nd_sh[47:0];
          sparsity <= {sparsity[62:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
      end
      default: begin
      end
    endcase
  end

  assign stat.step_done = (cnt == '0) || (cmd.op == csf_pkg::OP_POW_MUL && pph == 2'd2);
  assign stat.pow_huge = huge;

endmodule

// ===== rtl/csf_ctrl.sv =====
// Load sequencer and compute controller. Walks all pairs i<j, per pair
// all D coordinates, then sqrt, mean divide, power and divide by n.
module csf_ctrl #(
  parameter int MaxPoints = 64,
  parameter int MaxVars = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [15:0]                             coord,
  input  logic                                    eop,
  input  logic                                    eoc,
  input  logic [3:0]                              num_vars,
  output logic                                    we,
  output logic [$clog2(MaxPoints*MaxVars)-1:0]    waddr,
  output logic [15:0]                             wdata,
  output logic [$clog2(MaxPoints*MaxVars)-1:0]    raddr,
  output csf_pkg::dp_cmd_t                        cmd,
  input  csf_pkg::dp_stat_t                       stat,
  output logic [19:0]                             npairs,
  output logic [10:0]                             npts,
  output logic                                    res_valid,
  output logic [1:0]                              res_status,
  output logic                                    res_sat,
  input  logic                                    res_taken
);

  localparam int AddrW = $clog2(MaxPoints * MaxVars);
  localparam int PW = $clog2(MaxPoints + 1);
  localparam int VW = $clog2(MaxVars + 1);

  typedef enum logic [4:0] {
    S_LOAD, S_FILL, S_CHECK, S_PAIR, S_RDA, S_RDB, S_LATCH, S_TERM,
    S_SQ0, S_SQ, S_ADDD, S_NEXTP, S_DIV0, S_DIV, S_PINIT, S_PMUL,
    S_PSH, S_ND0, S_ND, S_OUT
  } state_t;

  state_t state;
  logic [PW-1:0] count;
  logic [VW-1:0] cidx;
  logic          ovf;
  logic [PW-1:0] pi;
  logic [PW-1:0] pj;
  logic [VW-1:0] c;
  logic [VW-1:0] dclamp;
  logic [3:0]    k;
  logic          room;
  logic          at_b;

  assign dclamp = (32'(num_vars) < MaxVars) ? VW'(num_vars) : VW'(MaxVars);
  assign room = 32'(count) < MaxPoints;
  assign in_ready = (state == S_LOAD);
  assign npts = 11'(count);
  assign npairs = 20'(32'(count) * (32'(count) - 1) / 2);

  always_comb begin
    cmd.op = csf_pkg::OP_IDLE;
    cmd.load_a = 1'b0;
    cmd.load_b = 1'b0;
    we = 1'b0;
    waddr = AddrW'(32'(count) * MaxVars + 32'(cidx));
    wdata = coord;
    raddr = AddrW'((at_b ? 32'(pj) : 32'(pi)) * MaxVars + 32'(c));
    case (state)
      S_LOAD: we = in_valid && room && (32'(cidx) < MaxVars);
      S_FILL: begin
        we = 1'b1;
        wdata = '0;
      end
      S_CHECK: cmd.op = csf_pkg::OP_CLEAR_AB;
      S_RDB: cmd.load_a = 1'b1;
      S_LATCH: cmd.load_b = 1'b1;
      S_TERM: cmd.op = csf_pkg::OP_ADD_TERM;
      S_SQ0: cmd.op = csf_pkg::OP_SQRT_START;
      S_SQ: cmd.op = csf_pkg::OP_SQRT_STEP;
      S_ADDD: cmd.op = csf_pkg::OP_ADD_DIST;
      S_DIV0: cmd.op = csf_pkg::OP_DIV_START;
      S_DIV: cmd.op = csf_pkg::OP_DIV_STEP;
      S_PINIT: cmd.op = csf_pkg::OP_POW_INIT;
      S_PMUL: cmd.op = csf_pkg::OP_POW_MUL;
      S_PSH: cmd.op = csf_pkg::OP_POW_SHIFT;
      S_ND0: cmd.op = csf_pkg::OP_NDIV_START;
      S_ND: cmd.op = csf_pkg::OP_NDIV_STEP;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      cidx <= '0;
      ovf <= 1'b0;
      res_valid <= 1'b0;
      res_status <= csf_pkg::STATUS_OK;
      res_sat <= 1'b0;
      at_b <= 1'b0;
      pi <= '0;
      pj <= '0;
      c <= '0;
      k <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (32'(cidx) < MaxVars) cidx <= cidx + 1'b1;
            if (eop || eoc) begin
              if (!room) begin
                ovf <= 1'b1;
                cidx <= '0;
                if (eoc) state <= S_CHECK;
              end else if (32'(cidx) + 1 < MaxVars) begin
                cidx <= cidx + 1'b1;
                state <= S_FILL;
                k <= {3'd0, eoc};
              end else begin
                count <= count + 1'b1;
                cidx <= '0;
                if (eoc) state <= S_CHECK;
              end
            end
          end
        end
        S_FILL: begin
          if (32'(cidx) + 1 >= MaxVars) begin
            count <= count + 1'b1;
            cidx <= '0;
            state <= k[0] ? S_CHECK : S_LOAD;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        S_CHECK: begin
          if (ovf) begin
            res_status <= csf_pkg::STATUS_OVF;
            res_sat <= 1'b0;
            res_valid <= 1'b1;
            state <= S_OUT;
          end else if (count < PW'(2)) begin
            res_status <= csf_pkg::STATUS_FEW;
            res_sat <= 1'b0;
            res_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            pi <= '0;
            pj <= PW'(1);
            state <= S_PAIR;
          end
        end
        S_PAIR: begin
          c <= '0;
          state <= (dclamp == '0) ? S_SQ0 : S_RDA;
        end
        S_RDA: begin
          at_b <= 1'b1;
          state <= S_RDB;
        end
        S_RDB: begin
          at_b <= 1'b0;
          state <= S_LATCH;
        end
        S_LATCH: state <= S_TERM;
        S_TERM: begin
          c <= c + 1'b1;
          state <= (c + 1'b1 == dclamp) ? S_SQ0 : S_RDA;
        end
        S_SQ0: state <= S_SQ;
        S_SQ: if (stat.step_done) state <= S_ADDD;
        S_ADDD: state <= S_NEXTP;
        S_NEXTP: begin
          if (pj + 1'b1 < count) begin
            pj <= pj + 1'b1;
            state <= S_PAIR;
          end else if (pi + PW'(2) < count) begin
            pi <= pi + 1'b1;
            pj <= pi + PW'(2);
            state <= S_PAIR;
          end else begin
            state <= S_DIV0;
          end
        end
        S_DIV0: state <= S_DIV;
        S_DIV: if (stat.step_done) state <= S_PINIT;
        S_PINIT: begin
          k <= '0;
          state <= (dclamp == '0) ? S_ND0 : S_PMUL;
        end
        S_PMUL: if (stat.step_done) state <= S_PSH;
        S_PSH: begin
          k <= k + 1'b1;
          state <= (VW'(k + 1'b1) == dclamp) ? S_ND0 : S_PMUL;
        end
        S_ND0: state <= S_ND;
        S_ND: begin
          if (stat.step_done) begin
            res_status <= csf_pkg::STATUS_OK;
            res_sat <= stat.pow_huge;
            res_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_taken) begin
            res_valid <= 1'b0;
            count <= '0;
            cidx <= '0;
            ovf <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== rtl/cluster_sparsity_factor.sv =====
// Cluster sparsity factor.
// Slave stream: s_tdata = coord, s_tuser = {end_of_cluster, end_of_point};
// one coordinate per beat; takes one beat per cycle while loading, stalling
// while a short point is zero-filled. On end_of_cluster the input stalls
// while the controller walks all n(n-1)/2 pairs (D coordinate terms and a
// square root per pair), then a mean divide, D power steps and a divide
// by n. One result beat on the master stream; it holds until m_tready.
// Register num_vars at APB address 0 (reset 2). Reset clears the counts;
// the point store is not cleared, every used slot is written first.
// Error status results are emitted immediately with zero data.
module cluster_sparsity_factor #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_VARS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // coord
  input  logic [1:0]   s_tuser,   // end_of_point, end_of_cluster
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // sparsity, mean_distance, saturated, status, pad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AddrW = $clog2(MAX_POINTS * MAX_VARS);

  logic [3:0] num_vars;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;
  csf_pkg::dp_cmd_t cmd;
  csf_pkg::dp_stat_t stat;
  logic [19:0] npairs;
  logic [10:0] npts;
  logic [1:0] res_status;
  logic res_sat;
  logic [31:0] mean;
  logic [63:0] sparsity;
  logic ok;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? {28'd0, num_vars} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars <= 4'd2;
    end else if (psel && penable && pwrite && paddr == 2'(csf_pkg::REG_NUM_VARS)) begin
      num_vars <= pwdata[3:0];
    end
  end

  csf_ram #(.Width(16), .Depth(MAX_POINTS * MAX_VARS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  csf_ctrl #(.MaxPoints(MAX_POINTS), .MaxVars(MAX_VARS)) u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .coord(s_tdata),
    .eop(s_tuser[0]), .eoc(s_tuser[1]), .num_vars, .we, .waddr, .wdata, .raddr,
    .cmd, .stat, .npairs, .npts, .res_valid(m_tvalid), .res_status, .res_sat,
    .res_taken(m_tready)
  );

  csf_datapath u_dp (
    .clk, .cmd, .rdata, .npairs, .npts, .stat, .mean, .sparsity
  );

  assign ok = (res_status == csf_pkg::STATUS_OK);
  assign m_tdata[63:0] = !ok ? 64'd0 : (res_sat ? '1 : sparsity);
  assign m_tdata[95:64] = ok ? mean : 32'd0;
  assign m_tdata[96] = ok & res_sat;
  assign m_tdata[98:97] = res_status;
  assign m_tdata[103:99] = '0;

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input open while result pending");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_status != csf_pkg::STATUS_OK) |-> m_tdata[96:0] == '0)
    else $error("error result carries data");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_status != 2'd3) else $error("bad status");
`endif

endmodule
